@@ rtl/sssd_pkg.sv @@
// ============================================================================
// Scrolling seven-segment driver package
// Shared constants, font table, result pin type and a helper function.
// ============================================================================
package sssd_pkg;

   // Default sizes handed to the top level's parameters.
   localparam int TEXT_LEN_DEFAULT   = 64;
   localparam int MAX_DIGITS_DEFAULT = 4;

   // The display has at most four digit positions; two in short mode.
   localparam int         DISPLAY_DIGITS = 4;
   localparam logic [2:0] DIGITS_SHORT   = 3'd2;

   // Positions past the end of the store that a window fill may look at.
   localparam int POS_MARGIN = 16;

   // Transaction opcodes.
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Configuration port.
   localparam int              CSR_INDEX_W      = 3;
   localparam int              CSR_DATA_W       = 16;
   localparam logic [2:0]      CSR_FOUR_DIGIT   = 3'd0;
   localparam logic [2:0]      CSR_COMMON_ANODE = 3'd1;
   localparam logic [2:0]      CSR_END_DWELL    = 3'd2;
   localparam logic [2:0]      CSR_START_DWELL  = 3'd3;
   localparam logic [2:0]      CSR_STEP_DWELL   = 3'd4;
   localparam logic [15:0]     END_DWELL_RESET   = 16'd2000;
   localparam logic [15:0]     START_DWELL_RESET = 16'd1000;
   localparam logic [15:0]     STEP_DWELL_RESET  = 16'd300;

   // Character codes.
   localparam logic [7:0] CHAR_NUL         = 8'h00;
   localparam logic [7:0] CHAR_DOT         = 8'h2E;
   localparam logic [7:0] CHAR_COMMA       = 8'h2C;
   localparam logic [7:0] CHAR_DEGREE      = 8'hB0;
   localparam logic [7:0] CHAR_FIRST_PRINT = 8'h20;
   localparam logic [7:0] CHAR_LAST_PRINT  = 8'h7F;

   // Segment patterns.
   localparam logic [7:0] SEG_DEGREE  = 8'h63;
   localparam logic [7:0] SEG_POINT   = 8'h80;
   localparam logic [7:0] SEG_UNKNOWN = 8'h08;
   localparam logic [7:0] SEG_BLANK   = 8'h00;

   // Digit 0 drives bit 3 of the digit pins.
   localparam logic [3:0] DIGIT0_ENABLE = 4'b1000;

   localparam int FONT_SIZE = 128 - 32;

   localparam logic [7:0] FONT [FONT_SIZE] = '{
      8'h00, 8'h86, 8'h22, 8'h08, 8'h08, 8'h08, 8'h08, 8'h02,
      8'h39, 8'h0f, 8'h08, 8'h46, 8'h80, 8'h40, 8'h80, 8'h08,
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
      8'h7f, 8'h6f, 8'h08, 8'h08, 8'h08, 8'h48, 8'h08, 8'h53,
      8'h08, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h3d,
      8'h76, 8'h06, 8'h0e, 8'h08, 8'h38, 8'h54, 8'h54, 8'h3f,
      8'h73, 8'h67, 8'h31, 8'h6d, 8'h78, 8'h3e, 8'h08, 8'h08,
      8'h08, 8'h6e, 8'h49, 8'h39, 8'h08, 8'h0f, 8'h01, 8'h08,
      8'h20, 8'h5f, 8'h7c, 8'h58, 8'h5e, 8'h7b, 8'h71, 8'h3d,
      8'h74, 8'h04, 8'h0c, 8'h08, 8'h30, 8'h08, 8'h54, 8'h5c,
      8'h73, 8'h67, 8'h50, 8'h6d, 8'h78, 8'h1c, 8'h08, 8'h08,
      8'h08, 8'h6e, 8'h49, 8'h39, 8'h30, 8'h0f, 8'h40, 8'h5d
   };

   // Segment and digit pins of one result, at pin polarity.
   typedef struct packed {
      logic [7:0] seg;
      logic [3:0] dig;
   } pins_type;

   // A period or a comma folds into the decimal point of a digit.
   function automatic logic is_dot(input logic [7:0] c);
      return (c == CHAR_DOT) || (c == CHAR_COMMA);
   endfunction

endpackage

@@ rtl/scrolling_seven_segment_driver.sv @@
// ============================================================================
// Scrolling seven-segment driver
// Multiplexed two- or four-digit display driver with a scrolling text window
// kept in a text memory with separate write and read ports.
// ============================================================================
//
//   Channel   Direction  Handshake          Carries
//   req_      in         req_valid/stall    character write or time tick
//   rsp_      out        rsp_valid/stall    pins for one lit digit + window
//   csr_      in         csr_wr_en          register index and write data
//
// A character write without the last mark leaves the block idle; a tick that does not
// scroll passes through scan, dwell and emit before the next acceptance. A scrolling
// tick adds a step, a check of the new first character (none on a wrap to the start)
// and a refill reading one text entry per cycle; a last-mark write runs the refill and
// then a zero tick. Reset clears the text (via valid bits), the window, scan, dwell and
// start at once. A result waits in the output register while rsp_stall is high; only
// the final load of the next result waits on it.
//
module scrolling_seven_segment_driver #(
   parameter int TEXT_LEN   = sssd_pkg::TEXT_LEN_DEFAULT,
   parameter int MAX_DIGITS = sssd_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input transactions
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [5:0]                       req_char_index,
   input  logic [7:0]                       req_char_value,
   input  logic                             req_last_char,
   input  logic [7:0]                       req_elapsed_ms,
   // Result transactions
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_segment_pins,
   output logic [3:0]                       rsp_digit_pins,
   output logic [1:0]                       rsp_digit_lit,
   output logic [5:0]                       rsp_window_start,
   output logic                             rsp_at_end,
   // Configuration writes
   input  logic                             csr_wr_en,
   input  logic [sssd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sssd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Text positions need room past the store for the look-ahead of a fill.
   localparam int         POS_W       = $clog2(TEXT_LEN + sssd_pkg::POS_MARGIN);
   localparam logic [2:0] DIGITS_FULL = 3'((MAX_DIGITS > sssd_pkg::DISPLAY_DIGITS) ?
                                           sssd_pkg::DISPLAY_DIGITS : MAX_DIGITS);

   typedef enum logic [12:0] {
      S_IDLE       = 13'b0000000000001,
      S_SCAN       = 13'b0000000000010,
      S_DWELL      = 13'b0000000000100,
      S_ADV        = 13'b0000000001000,
      S_CHK_PREV   = 13'b0000000010000,
      S_CHK_CUR    = 13'b0000000100000,
      S_CHK_DONE   = 13'b0000001000000,
      S_FILL_PREV  = 13'b0000010000000,
      S_FILL_CUR   = 13'b0000100000000,
      S_FILL_NEXT  = 13'b0001000000000,
      S_FILL_DIGIT = 13'b0010000000000,
      S_FILL_TERM  = 13'b0100000000000,
      S_EMIT       = 13'b1000000000000
   } state_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic               four_digit_ff;
   logic               common_anode_ff;
   logic [15:0]        end_dwell_ff, start_dwell_ff, step_dwell_ff;

   logic [1:0]         scan_ff, scan_in;
   logic [15:0]        dwell_ff, dwell_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic               end_ff, end_in;
   logic [7:0]         win_char_ff [sssd_pkg::DISPLAY_DIGITS];
   logic [7:0]         win_char_in [sssd_pkg::DISPLAY_DIGITS];
   logic [3:0]         win_point_ff, win_point_in;

   logic [7:0]         ms_ff, ms_in;
   logic               after_load_ff, after_load_in;
   logic               prev_dot_ff, prev_dot_in;
   logic [POS_W-1:0]   fill_pos_ff, fill_pos_in;
   logic [1:0]         fill_digit_ff, fill_digit_in;
   logic [7:0]         cur_char_ff, cur_char_in;
   sssd_pkg::pins_type res_pins_ff, res_pins_in;
   logic [1:0]         res_digit_ff, res_digit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   sssd_pkg::pins_type rsp_pins_ff, rsp_pins_in;
   logic [1:0]         rsp_digit_ff, rsp_digit_in;
   logic [5:0]         rsp_start_ff, rsp_start_in;
   logic               rsp_end_ff, rsp_end_in;

   // ---------------------------------------------------------------------
   // Combinational helpers
   // ---------------------------------------------------------------------
   logic               req_fire;
   logic               store_wr;
   logic [POS_W-1:0]   rd_pos;
   logic [7:0]         rd_char;
   logic [2:0]         digit_total;
   logic [1:0]         scan_sel;
   logic [2:0]         scan_next;
   sssd_pkg::pins_type glyph_pins;
   logic [15:0]        dwell_move;
   logic               dwell_chosen;
   logic [7:0]         dig_char;
   logic               dig_point;
   logic               dig_skip;
   logic               dig_last;
   logic               rsp_free;
   state_type          post_fill;

   assign req_fire    = req_valid && !req_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign store_wr    = req_fire && (req_opcode == sssd_pkg::OP_CHAR);
   assign digit_total = four_digit_ff ? DIGITS_FULL : sssd_pkg::DIGITS_SHORT;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign post_fill   = after_load_ff ? S_SCAN : S_EMIT;

   // If the digit count shrank under the scan, the scan restarts at digit 0.
   assign scan_sel  = ({1'b0, scan_ff} >= digit_total) ? 2'd0 : scan_ff;
   assign scan_next = 3'(scan_sel) + 3'd1;

   sssd_text_store #(
      .TEXT_LEN (TEXT_LEN),
      .POS_W    (POS_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (store_wr),
      .clear   (store_wr && (req_char_index == 6'd0)),
      .wr_pos  (POS_W'(req_char_index)),
      .wr_data (req_char_value),
      .rd_pos  (rd_pos),
      .rd_char (rd_char)
   );

   sssd_glyph u_glyph (
      .char_code (win_char_ff[scan_sel]),
      .point     (win_point_ff[scan_sel]),
      .digit     (scan_sel),
      .invert    (common_anode_ff),
      .pins      (glyph_pins)
   );

   // Read address for the store. Its read data is registered,
   // so each state names the entry that the following state consumes.
   always_comb begin
      case (state_ff)
         S_CHK_PREV,
         S_FILL_PREV:  rd_pos = start_ff - POS_W'(1);
         S_CHK_CUR:    rd_pos = start_ff;
         S_FILL_CUR:   rd_pos = fill_pos_ff;
         S_FILL_NEXT:  rd_pos = fill_pos_ff + POS_W'(1);
         S_FILL_DIGIT: rd_pos = fill_pos_ff + POS_W'(2);
         default:      rd_pos = start_ff;
      endcase
   end

   // Dwell branch selection: end hold, start hold, then the step hold.
   always_comb begin
      dwell_move   = 16'd0;
      dwell_chosen = 1'b0;
      if (end_ff && (dwell_ff >= end_dwell_ff)) begin
         dwell_move   = end_dwell_ff;
         dwell_chosen = 1'b1;
      end else if ((start_ff == '0) && (dwell_ff >= start_dwell_ff)) begin
         dwell_move   = start_dwell_ff;
         dwell_chosen = 1'b1;
      end else if ((start_ff != '0) && (dwell_ff >= step_dwell_ff) && !end_ff) begin
         dwell_move   = step_dwell_ff;
         dwell_chosen = 1'b1;
      end
   end

   // One window digit from the current character and the one after it
   // (rd_char in S_FILL_DIGIT). A dot after a character becomes its point;
   // a dot after a dotted digit stands alone with its point lit; a leading
   // dot is skipped. dig_skip means two text positions were consumed.
   always_comb begin
      dig_char  = cur_char_ff;
      dig_point = 1'b0;
      dig_skip  = 1'b0;
      if (sssd_pkg::is_dot(cur_char_ff)) begin
         if (prev_dot_ff) begin
            dig_char  = sssd_pkg::CHAR_DOT;
            dig_point = 1'b1;
         end else begin
            dig_char = rd_char;
            dig_skip = (rd_char != sssd_pkg::CHAR_NUL);
         end
      end else if (sssd_pkg::is_dot(rd_char)) begin
         dig_point = 1'b1;
         dig_skip  = 1'b1;
      end
      dig_last = ((3'(fill_digit_ff) + 3'd1) == digit_total);
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      dwell_in      = dwell_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      win_char_in   = win_char_ff;
      win_point_in  = win_point_ff;
      ms_in         = ms_ff;
      after_load_in = after_load_ff;
      prev_dot_in   = prev_dot_ff;
      fill_pos_in   = fill_pos_ff;
      fill_digit_in = fill_digit_ff;
      cur_char_in   = cur_char_ff;
      res_pins_in   = res_pins_ff;
      res_digit_in  = res_digit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pins_in   = rsp_pins_ff;
      rsp_digit_in  = rsp_digit_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_opcode == sssd_pkg::OP_TICK) begin
                  ms_in         = req_elapsed_ms;
                  after_load_in = 1'b0;
                  state_in      = S_SCAN;
               end else if (req_last_char) begin
                  // Restart the scroll; the refill is followed by a zero tick.
                  start_in      = '0;
                  end_in        = 1'b0;
                  dwell_in      = 16'd0;
                  ms_in         = 8'd0;
                  after_load_in = 1'b1;
                  win_point_in  = '0;
                  for (int j = 0; j < sssd_pkg::DISPLAY_DIGITS; j++) begin
                     win_char_in[j] = sssd_pkg::CHAR_NUL;
                  end
                  state_in = S_FILL_PREV;
               end
            end
         end

         S_SCAN: begin
            res_pins_in  = glyph_pins;
            res_digit_in = scan_sel;
            scan_in      = (scan_next >= digit_total) ? 2'd0 : scan_next[1:0];
            dwell_in     = dwell_ff + 16'(ms_ff);
            state_in     = S_DWELL;
         end

         S_DWELL: begin
            if (dwell_chosen && (dwell_move != 16'd0)) begin
               dwell_in = dwell_ff - dwell_move;
               state_in = S_ADV;
            end else begin
               state_in = S_EMIT;
            end
         end

         S_ADV: begin
            if (end_ff) begin
               start_in = '0;
               end_in   = 1'b0;
               state_in = S_FILL_PREV;
            end else begin
               start_in = start_ff + POS_W'(1);
               state_in = S_CHK_PREV;
            end
         end

         S_CHK_PREV: begin
            state_in = S_CHK_CUR;
         end

         S_CHK_CUR: begin
            prev_dot_in = sssd_pkg::is_dot(rd_char);
            state_in    = S_CHK_DONE;
         end

         S_CHK_DONE: begin
            // A window never opens on a dot that belongs to a character.
            if (sssd_pkg::is_dot(rd_char) && !prev_dot_ff) begin
               start_in = start_ff + POS_W'(1);
            end
            state_in = S_FILL_PREV;
         end

         S_FILL_PREV: begin
            fill_pos_in   = start_ff;
            fill_digit_in = 2'd0;
            state_in      = S_FILL_CUR;
         end

         S_FILL_CUR: begin
            prev_dot_in = (start_ff != '0) && sssd_pkg::is_dot(rd_char);
            state_in    = S_FILL_NEXT;
         end

         S_FILL_NEXT: begin
            cur_char_in = rd_char;
            state_in    = S_FILL_DIGIT;
         end

         S_FILL_DIGIT: begin
            if (cur_char_ff == sssd_pkg::CHAR_NUL) begin
               // End of text: this digit and the rest of the window go blank.
               end_in = 1'b1;
               for (int j = 0; j < sssd_pkg::DISPLAY_DIGITS; j++) begin
                  if ((3'(j) >= 3'(fill_digit_ff)) && (3'(j) < digit_total)) begin
                     win_char_in[j]  = sssd_pkg::CHAR_NUL;
                     win_point_in[j] = 1'b0;
                  end
               end
               state_in = post_fill;
            end else begin
               win_char_in[fill_digit_ff]  = dig_char;
               win_point_in[fill_digit_ff] = dig_point;
               prev_dot_in                 = dig_point;
               fill_pos_in = fill_pos_ff + (dig_skip ? POS_W'(2) : POS_W'(1));
               if (!dig_skip) begin
                  // The look-ahead character becomes the current one.
                  cur_char_in = rd_char;
                  if (dig_last) begin
                     end_in   = (rd_char == sssd_pkg::CHAR_NUL);
                     state_in = post_fill;
                  end else begin
                     fill_digit_in = fill_digit_ff + 2'd1;
                     state_in      = S_FILL_DIGIT;
                  end
               end else if (dig_last) begin
                  state_in = S_FILL_TERM;
               end else begin
                  fill_digit_in = fill_digit_ff + 2'd1;
                  state_in      = S_FILL_NEXT;
               end
            end
         end

         S_FILL_TERM: begin
            if (rd_char == sssd_pkg::CHAR_NUL) begin
               end_in = 1'b1;
            end
            state_in = post_fill;
         end

         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pins_in  = res_pins_ff;
               rsp_digit_in = res_digit_ff;
               rsp_start_in = 6'(start_ff);
               rsp_end_in   = end_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_ff       <= 2'd0;
         dwell_ff      <= 16'd0;
         start_ff      <= '0;
         end_ff        <= 1'b0;
         win_point_ff  <= '0;
         after_load_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int j = 0; j < sssd_pkg::DISPLAY_DIGITS; j++) begin
            win_char_ff[j] <= sssd_pkg::CHAR_NUL;
         end
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         dwell_ff      <= dwell_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         win_point_ff  <= win_point_in;
         after_load_ff <= after_load_in;
         rsp_valid_ff  <= rsp_valid_in;
         win_char_ff   <= win_char_in;
      end
   end

   // Working and result payload.
   always_ff @(posedge clock) begin
      ms_ff         <= ms_in;
      prev_dot_ff   <= prev_dot_in;
      fill_pos_ff   <= fill_pos_in;
      fill_digit_ff <= fill_digit_in;
      cur_char_ff   <= cur_char_in;
      res_pins_ff   <= res_pins_in;
      res_digit_ff  <= res_digit_in;
      rsp_pins_ff   <= rsp_pins_in;
      rsp_digit_ff  <= rsp_digit_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         four_digit_ff   <= 1'b1;
         common_anode_ff <= 1'b0;
         end_dwell_ff    <= sssd_pkg::END_DWELL_RESET;
         start_dwell_ff  <= sssd_pkg::START_DWELL_RESET;
         step_dwell_ff   <= sssd_pkg::STEP_DWELL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sssd_pkg::CSR_FOUR_DIGIT:   four_digit_ff   <= csr_wdata[0];
            sssd_pkg::CSR_COMMON_ANODE: common_anode_ff <= csr_wdata[0];
            sssd_pkg::CSR_END_DWELL:    end_dwell_ff    <= csr_wdata;
            sssd_pkg::CSR_START_DWELL:  start_dwell_ff  <= csr_wdata;
            sssd_pkg::CSR_STEP_DWELL:   step_dwell_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segment_pins = rsp_pins_ff.seg;
   assign rsp_digit_pins   = rsp_pins_ff.dig;
   assign rsp_digit_lit    = rsp_digit_ff;
   assign rsp_window_start = rsp_start_ff;
   assign rsp_at_end       = rsp_end_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // An accepted tick always starts the sequencer, which then stalls further requests.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_opcode == sssd_pkg::OP_TICK)) |=> req_stall)
      else $error("tick transaction did not start the sequencer");

   // The window fill never walks past the active digit count.
   a_fill_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL_DIGIT) |-> ({1'b0, fill_digit_ff} < digit_total))
      else $error("window fill digit beyond the digit count");

   // After the scan step the next digit to light is a valid one.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DWELL) |-> ({1'b0, scan_ff} < digit_total))
      else $error("scan digit beyond the digit count");

   // A result is loaded only from the emit step.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == S_EMIT))
      else $error("result loaded outside the emit step");

endmodule

@@ rtl/sssd_text_store.sv @@
// ============================================================================
// Text store
// Character memory with separate write and read ports, per-entry valid bits and a
// registered, masked read; entries that were never written or lie past the end read zero.
// ============================================================================
module sssd_text_store #(
   parameter int TEXT_LEN = sssd_pkg::TEXT_LEN_DEFAULT,
   parameter int POS_W    = $clog2(TEXT_LEN + sssd_pkg::POS_MARGIN)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic             clear,
   input  logic [POS_W-1:0] wr_pos,
   input  logic [7:0]       wr_data,
   input  logic [POS_W-1:0] rd_pos,
   output logic [7:0]       rd_char
);

   localparam int               ADDR_W = $clog2(TEXT_LEN);
   localparam logic [POS_W-1:0] LIMIT  = POS_W'(TEXT_LEN);

   logic [7:0]          mem [TEXT_LEN];
   logic [TEXT_LEN-1:0] valid_ff, valid_in;
   logic [7:0]          rd_data_ff;
   logic                rd_hit_ff;
   logic                wr_hit;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;

   assign wr_hit  = wr_en && (wr_pos < LIMIT);
   assign wr_addr = wr_pos[ADDR_W-1:0];
   assign rd_addr = rd_pos[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // A clear drops every entry; a write in the same cycle still lands.
   always_comb begin
      valid_in = clear ? '0 : valid_ff;
      if (wr_hit) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= (rd_pos < LIMIT) && valid_ff[rd_addr];
      end
   end

   assign rd_char = rd_hit_ff ? rd_data_ff : sssd_pkg::CHAR_NUL;

endmodule

@@ rtl/sssd_glyph.sv @@
// ============================================================================
// Glyph encoder
// Maps a character and point flag to segment pins and a digit to its enable,
// both at pin polarity.
// ============================================================================
module sssd_glyph (
   input  logic                 [7:0] char_code,
   input  logic                       point,
   input  logic                 [1:0] digit,
   input  logic                       invert,
   output sssd_pkg::pins_type         pins
);

   logic [6:0] font_idx;
   logic [7:0] shape;
   logic [7:0] seg;
   logic [3:0] dig;

   always_comb begin
      font_idx = 7'(char_code - sssd_pkg::CHAR_FIRST_PRINT);
      if (char_code == sssd_pkg::CHAR_DEGREE) begin
         shape = sssd_pkg::SEG_DEGREE;
      end else if (char_code == sssd_pkg::CHAR_NUL) begin
         shape = sssd_pkg::SEG_BLANK;
      end else if ((char_code < sssd_pkg::CHAR_FIRST_PRINT) ||
                   (char_code > sssd_pkg::CHAR_LAST_PRINT)) begin
         shape = sssd_pkg::SEG_UNKNOWN;
      end else begin
         shape = sssd_pkg::FONT[font_idx];
      end
      seg = shape | (point ? sssd_pkg::SEG_POINT : sssd_pkg::SEG_BLANK);
      dig = sssd_pkg::DIGIT0_ENABLE >> digit;
      pins.seg = invert ? ~seg : seg;
      pins.dig = invert ? ~dig : dig;
   end

endmodule
